[design/euler_rotation_translation_matrix_macros.svh]
// Assertion helpers for the top-level design file.
`ifndef EULER_ROTATION_TRANSLATION_MATRIX_MACROS_SVH
`define EULER_ROTATION_TRANSLATION_MATRIX_MACROS_SVH

// Implication checked on every edge outside reset.
`define ERTM_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ertm check failed");

// Implication checked in the cycle after the antecedent.
`define ERTM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ertm check failed");

`endif

[design/ertm_pkg.sv]
package ertm_pkg;
  localparam int unsigned AngW     = 17;
  localparam int unsigned OrgW     = 32;
  localparam int unsigned ColW     = 32;
  localparam int unsigned CordW    = 34;
  localparam int unsigned FullTurn = 46080;
  localparam int unsigned HalfTurn = 23040;
  localparam int unsigned QuarterTurn = 11520;
  localparam logic signed [CordW-1:0] CordicGain = 34'sd652032874;
  localparam int unsigned RadScale = 9370165;

  // angle, rotation and flip flag for one CORDIC lane
  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [CordW-1:0] z;
    logic                    flip;
  } lane_t;

  // words moving along the cell chain
  typedef struct packed {
    logic              vld;
    lane_t             p;
    lane_t             yw;
    lane_t             r;
    logic [3*OrgW-1:0] org;
  } chain_t;

  function automatic logic signed [CordW-1:0] atan_q30(input logic [4:0] k);
    logic signed [CordW-1:0] t;
    case (k)
      5'd0: t = 34'sd843314856;  5'd1: t = 34'sd497837829;
      5'd2: t = 34'sd263043836;  5'd3: t = 34'sd133525158;
      5'd4: t = 34'sd66958190;   5'd5: t = 34'sd33510235;
      5'd6: t = 34'sd16775850;   5'd7: t = 34'sd8388437;
      5'd8: t = 34'sd4194282;    5'd9: t = 34'sd2097149;
      5'd10: t = 34'sd1048575;   5'd11: t = 34'sd524287;
      5'd12: t = 34'sd262143;    5'd13: t = 34'sd131071;
      5'd14: t = 34'sd65535;     5'd15: t = 34'sd32767;
      5'd16: t = 34'sd16383;     5'd17: t = 34'sd8191;
      5'd18: t = 34'sd4095;      5'd19: t = 34'sd2047;
      5'd20: t = 34'sd1023;      5'd21: t = 34'sd511;
      5'd22: t = 34'sd255;       5'd23: t = 34'sd127;
      5'd24: t = 34'sd63;        5'd25: t = 34'sd31;
      5'd26: t = 34'sd15;        5'd27: t = 34'sd8;
      5'd28: t = 34'sd4;         5'd29: t = 34'sd2;
      5'd30: t = 34'sd1;         default: t = '0;
    endcase
    return t;
  endfunction

  function automatic lane_t lane_step(input lane_t a, input logic [4:0] k);
    lane_t o;
    o = a;
    if (!a.z[CordW-1]) begin
      o.x = a.x - (a.y >>> k);
      o.y = a.y + (a.x >>> k);
      o.z = a.z - atan_q30(k);
    end else begin
      o.x = a.x + (a.y >>> k);
      o.y = a.y - (a.x >>> k);
      o.z = a.z + atan_q30(k);
    end
    return o;
  endfunction
endpackage

[design/ertm_reduce.sv]
// Angle reduction and conversion to Q4.30 radians, two register stages.
module ertm_reduce import ertm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [AngW-1:0] ang_i,
  output lane_t                  lane_o
);
  localparam logic signed [17:0] FullS = 18'(FullTurn);

  logic signed [17:0] r_d, r_q;
  logic               flip_d, flip_q;
  logic signed [CordW+6:0] prod;
  lane_t lane_q;

  always_comb begin
    logic signed [17:0] m;
    // a 17 bit angle is less than two turns below 0 and less than one turn past FullTurn
    m = 18'(ang_i);
    if (m < 0) m = m + FullS;
    if (m < 0) m = m + FullS;
    if (m >= FullS) m = m - FullS;
    if (m >= 18'(HalfTurn)) m = m - 18'(FullTurn);
    flip_d = 1'b0;
    r_d = m;
    if (m > 18'sd11520) begin
      r_d = m - 18'(HalfTurn);
      flip_d = 1'b1;
    end else if (m < -18'sd11520) begin
      r_d = m + 18'(HalfTurn);
      flip_d = 1'b1;
    end
  end

  assign prod = 41'(r_q) * 41'sd9370165;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q <= r_d;
      flip_q <= flip_d;
      lane_q.x <= CordicGain;
      lane_q.y <= '0;
      // truncate toward zero
      lane_q.z <= CordW'(prod[CordW+6] ? -((-prod) >>> 6) : (prod >>> 6));
      lane_q.flip <= flip_q;
    end
  end
  assign lane_o = lane_q;
endmodule

[design/ertm_cell.sv]
// One CORDIC iteration for all three angles; hands its word to the next cell.
module ertm_cell import ertm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [4:0] k_i,
  input  chain_t     in_i,
  output chain_t     out_o
);
  logic              vld_q;
  lane_t             p_q, yw_q, r_q;
  logic [3*OrgW-1:0] org_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= in_i.vld;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q   <= lane_step(in_i.p, k_i);
      yw_q  <= lane_step(in_i.yw, k_i);
      r_q   <= lane_step(in_i.r, k_i);
      org_q <= in_i.org;
    end
  end
  assign out_o = '{vld: vld_q, p: p_q, yw: yw_q, r: r_q, org: org_q};
endmodule

[design/euler_rotation_translation_matrix.sv]
// Euler angles to 4x4 rotation-translation matrix. Each accepted word yields four
// row words (row 0 first, tlast on row 3). After each accepted word the input side
// holds tready low while a gap counter runs down, pacing input to the four row words
// on the single output channel. Row 0 passes two reduce stages, the chain of CORDIC
// cells with one iteration each, two product stages, then the row buffer; rows 1 to 3
// follow in order as the output takes them. The pipeline stalls as a whole while a
// finished matrix waits for the row buffer to finish the last row of the one before.
module euler_rotation_translation_matrix import ertm_pkg::*; #(
  parameter int unsigned CORDIC_ITERATIONS = 16,
  parameter int unsigned FRACTION_BITS     = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // pitch[16:0], yaw[33:17], roll[50:34], origin_x[82:51], origin_y[114:83],
  // origin_z[146:115], zero pad to 152
  input  logic [151:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // row_index[1:0], col0[33:2], col1[65:34], col2[97:66], col3[129:98], pad to 136
  output logic [135:0]  m_axis_tdata,
  output logic          m_axis_tlast
);
  `include "euler_rotation_translation_matrix_macros.svh"

  localparam int unsigned OutSh = 60 - FRACTION_BITS;

  logic en;
  logic [1:0] gap_q;
  logic v1_q, v2_q;
  logic [3*OrgW-1:0] org1_q, org2_q;
  lane_t lp, ly, lr;
  chain_t chain [CORDIC_ITERATIONS+1];

  // final rows buffer
  logic        ob_vld_q;
  logic [1:0]  ob_row_q;
  logic signed [ColW-1:0] m_q [3][3];
  logic [3*OrgW-1:0] ob_org_q;

  logic rows_busy;
  assign rows_busy = ob_vld_q && !(ob_row_q == 2'd3 && m_axis_tready);
  // the whole pipeline waits while the stage ahead of the row buffer holds a matrix and rows are still going out
  logic p1_vld_q, p2_vld_q;
  assign en = !(p2_vld_q && rows_busy);
  assign s_axis_tready = en && (gap_q == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= '0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid && s_axis_tready;
      v2_q <= v1_q;
      if (s_axis_tvalid && s_axis_tready) gap_q <= 2'd3;
      else if (gap_q != 2'd0) gap_q <= gap_q - 2'd1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      org1_q <= s_axis_tdata[146:51];
      org2_q <= org1_q;
    end
  end

  ertm_reduce u_rp (.clk_i, .en_i(en), .ang_i(s_axis_tdata[16:0]),  .lane_o(lp));
  ertm_reduce u_ry (.clk_i, .en_i(en), .ang_i(s_axis_tdata[33:17]), .lane_o(ly));
  ertm_reduce u_rr (.clk_i, .en_i(en), .ang_i(s_axis_tdata[50:34]), .lane_o(lr));

  assign chain[0] = '{vld: v2_q, p: lp, yw: ly, r: lr, org: org2_q};

  for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_cell
    ertm_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .k_i(5'(i)),
      .in_i(chain[i]), .out_o(chain[i+1])
    );
  end

  chain_t ce;
  assign ce = chain[CORDIC_ITERATIONS];
  logic signed [CordW-1:0] sp, cp, sy, cy, sr, cr;
  assign sp = ce.p.flip ? -ce.p.y : ce.p.y;
  assign cp = ce.p.flip ? -ce.p.x : ce.p.x;
  assign sy = ce.yw.flip ? -ce.yw.y : ce.yw.y;
  assign cy = ce.yw.flip ? -ce.yw.x : ce.yw.x;
  assign sr = ce.r.flip ? -ce.r.y : ce.r.y;
  assign cr = ce.r.flip ? -ce.r.x : ce.r.x;

  // stage p1: sines, cosines and pair products
  logic signed [CordW-1:0] sp1, cp1, sy1, cy1, sr1, cr1, srsp1, crsp1;
  logic [3*OrgW-1:0] org_p1;
  logic signed [67:0] srsp_w, crsp_w;
  assign srsp_w = 68'(sr) * 68'(sp);
  assign crsp_w = 68'(cr) * 68'(sp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
    end else if (en) begin
      p1_vld_q <= ce.vld;
      p2_vld_q <= p1_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sp1 <= sp; cp1 <= cp; sy1 <= sy; cy1 <= cy; sr1 <= sr; cr1 <= cr;
      srsp1 <= CordW'(srsp_w >>> 30);
      crsp1 <= CordW'(crsp_w >>> 30);
      org_p1 <= ce.org;
    end
  end

  // stage p2: Q60 products
  logic signed [67:0] pr [12];
  logic signed [CordW-1:0] sp2;
  logic [3*OrgW-1:0] org_p2;
  always_ff @(posedge clk_i) begin
    if (en) begin
      pr[0]  <= 68'(cp1) * 68'(cy1);
      pr[1]  <= 68'(cp1) * 68'(sy1);
      pr[2]  <= 68'(srsp1) * 68'(cy1);
      pr[3]  <= 68'(cr1) * 68'(sy1);
      pr[4]  <= 68'(srsp1) * 68'(sy1);
      pr[5]  <= 68'(cr1) * 68'(cy1);
      pr[6]  <= 68'(sr1) * 68'(cp1);
      pr[7]  <= 68'(crsp1) * 68'(cy1);
      pr[8]  <= 68'(sr1) * 68'(sy1);
      pr[9]  <= 68'(crsp1) * 68'(sy1);
      pr[10] <= 68'(cr1) * 68'(cp1);
      pr[11] <= 68'(sr1) * 68'(cy1);
      sp2 <= sp1;
      org_p2 <= org_p1;
    end
  end

  function automatic logic signed [ColW-1:0] q60(input logic signed [67:0] v);
    logic signed [67:0] t;
    t = v >>> OutSh;
    return t[ColW-1:0];
  endfunction

  logic signed [CordW-1:0] sp_sh;
  assign sp_sh = sp2 >>> (30 - FRACTION_BITS);

  // row buffer: loads the matrix when rows are free, then steps row by row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_vld_q <= 1'b0;
      ob_row_q <= '0;
    end else if (ob_vld_q && m_axis_tready) begin
      if (ob_row_q == 2'd3) begin
        ob_vld_q <= p2_vld_q;
        ob_row_q <= '0;
      end else begin
        ob_row_q <= ob_row_q + 2'd1;
      end
    end else if (!ob_vld_q) begin
      ob_vld_q <= p2_vld_q;
      ob_row_q <= '0;
    end
  end
  logic load;
  assign load = p2_vld_q && !rows_busy;
  always_ff @(posedge clk_i) begin
    if (load) begin
      m_q[0][0] <= q60(pr[0]);
      m_q[0][1] <= q60(pr[1]);
      m_q[0][2] <= sp_sh[ColW-1:0];
      m_q[1][0] <= q60(pr[2] - pr[3]);
      m_q[1][1] <= q60(pr[4] + pr[5]);
      m_q[1][2] <= q60(-pr[6]);
      m_q[2][0] <= q60(-(pr[7] + pr[8]));
      m_q[2][1] <= q60(pr[11] - pr[9]);
      m_q[2][2] <= q60(pr[10]);
      ob_org_q <= org_p2;
    end
  end

  logic [ColW-1:0] c0, c1, c2, c3;
  always_comb begin
    c3 = '0;
    unique case (ob_row_q)
      2'd0: begin c0 = m_q[0][0]; c1 = m_q[0][1]; c2 = m_q[0][2]; end
      2'd1: begin c0 = m_q[1][0]; c1 = m_q[1][1]; c2 = m_q[1][2]; end
      2'd2: begin c0 = m_q[2][0]; c1 = m_q[2][1]; c2 = m_q[2][2]; end
      default: begin
        c0 = ob_org_q[31:0];
        c1 = ob_org_q[63:32];
        c2 = ob_org_q[95:64];
        c3 = ColW'(64'd1 << FRACTION_BITS);
      end
    endcase
  end

  assign m_axis_tvalid = ob_vld_q;
  assign m_axis_tlast  = (ob_row_q == 2'd3);
  assign m_axis_tdata  = {6'd0, c3, c2, c1, c0, ob_row_q};

  `ERTM_ASSERT_IMP(a_tlast_row, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast,
                   ob_row_q == 2'd3)
  `ERTM_ASSERT_NEXT(a_gap, clk_i, rst_ni, s_axis_tvalid && s_axis_tready,
                    !s_axis_tready)
  `ERTM_ASSERT_NEXT(a_row_step, clk_i, rst_ni,
                    m_axis_tvalid && m_axis_tready && !m_axis_tlast,
                    m_axis_tvalid && ob_row_q == $past(ob_row_q) + 2'd1)
endmodule
